/* rtl/kst_pkg.sv */
// Shared types, register indexes, constants and saturation helper for the
// Know Sure Thing oscillator. No dependencies.
`default_nettype none
package kst_pkg;

  typedef struct packed {
    logic [31:0] price_sample;
    logic        last_in_series;
  } kst_in_t;

  typedef struct packed {
    logic signed [31:0] kst_value;
    logic signed [31:0] signal_value;
    logic               options_invalid;
    logic               divide_fault;
  } kst_out_t;

  localparam logic [2:0] REG_LOOKBACK_1 = 3'd0;
  localparam logic [2:0] REG_LOOKBACK_2 = 3'd1;
  localparam logic [2:0] REG_LOOKBACK_3 = 3'd2;
  localparam logic [2:0] REG_LOOKBACK_4 = 3'd3;
  localparam logic [2:0] REG_PERIOD_1   = 3'd4;
  localparam logic [2:0] REG_PERIOD_2   = 3'd5;
  localparam logic [2:0] REG_PERIOD_3   = 3'd6;
  localparam logic [2:0] REG_PERIOD_4   = 3'd7;

  localparam logic [2:0]  ST_SIG    = 3'd4;
  localparam logic [31:0] KST_DIV   = 32'd10;
  localparam logic [8:0]  INDEX_MAX = 9'd511;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh000000007FFFFFFF) begin
      res = S32_MAX;
    end else if (v < -64'sh0000000080000000) begin
      res = S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/kst_hist_ram.sv */
// Price history ring memory, one write and one registered read port.
// No package dependency.
`default_nettype none
module kst_hist_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

/* rtl/kst_state_ram.sv */
// Average store: four smoothed rates and the signal average, registered read,
// per-entry valid bits so a restart clears at once. Uses kst_pkg.
`default_nettype none
module kst_state_ram (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        clear,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_addr,
  input  wire logic [31:0] wr_data,
  input  wire logic        rd_en,
  input  wire logic [2:0]  rd_addr,
  output logic [31:0]      rd_data
);
  import kst_pkg::*;
  logic [31:0] mem [5];
  logic [4:0]  valid_r;
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : 32'd0;
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

/* rtl/kst_div.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// No package dependency.
`default_nettype none
module kst_div #(
  parameter int DW = 56
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [31:0]   divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [DW-1:0] dvd_r;
  logic [31:0]   dsr_r;
  logic [32:0]   rem_r;
  logic [32:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r[31:0], dvd_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - CW'(1);
        done_r <= (cnt_r == CW'(1));
      end
    end
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      dvd_r <= {dvd_r[DW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule
`default_nettype wire

/* rtl/know_sure_thing_oscillator_top.sv */
// Know Sure Thing oscillator top: sequencer, configuration registers, output
// register. Uses kst_pkg, kst_hist_ram, kst_state_ram, kst_div.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | kst_in_t
// out     | output    | out_valid / out_stall | kst_out_t
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. A valid item passes the idle state, then for each lookback either
// skips it or computes its rate and average on the shared divider (a seeded lookback
// takes its rate as the average); kst and signal are divided by ten with shifts and adds,
// then the output is registered. Invalid options go straight to the output.
// Synchronous reset restores register defaults and clears the series at once.
// A stalled output holds the finished transaction while the next item is taken.
`default_nettype none
module know_sure_thing_oscillator_top #(
  parameter int HISTORY_DEPTH = 256,
  parameter int FRACTION_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire kst_pkg::kst_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output kst_pkg::kst_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  import kst_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int DW = 32 + FRACTION_BITS;
  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
  localparam logic [2:0] D10_LAST = 3'd6;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOOK = 12'b000000000010,
    S_ROC  = 12'b000000000100,
    S_ROCW = 12'b000000001000,
    S_EMA  = 12'b000000010000,
    S_EMAW = 12'b000000100000,
    S_KST  = 12'b000001000000,
    S_KSTW = 12'b000010000000,
    S_SIG  = 12'b000100000000,
    S_SIGW = 12'b001000000000,
    S_OUT  = 12'b010000000000,
    S_INV  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]  lb_r  [4];
  logic [15:0] per_r [4];
  logic [1:0]  k_r, k_nxt;
  logic [31:0] x_r, x_nxt;
  logic        last_r, last_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic        fault_r, fault_nxt;
  logic        neg_r, neg_nxt;
  logic signed [31:0] e_r, e_nxt, r_r, r_nxt, kst_r, kst_nxt, sig_r, sig_nxt;
  logic signed [63:0] sum_r, sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  kst_out_t    out_data_r, out_data_nxt;
  logic [39:0] dq_r, dq_nxt, dn_r, dn_nxt;
  logic [2:0]  d10_step_r, d10_step_nxt;

  logic          hist_rd_en, hist_wr_en;
  logic [AW-1:0] hist_rd_addr;
  logic [31:0]   hist_rd;
  logic          st_rd_en, st_wr_en, st_clear;
  logic [2:0]    st_rd_addr, st_wr_addr;
  logic [31:0]   st_wr_data, st_rd;
  logic          div_start, div_done;
  logic [DW-1:0] div_dvd, div_q;
  logic [31:0]   div_dsr;

  logic [7:0]  lb_k;
  logic [15:0] per_k;
  logic        opt_ok, out_free, commit;
  logic [AW:0] pos_sum;
  logic [31:0] diff;
  logic signed [63:0] div_qs, e64, r64, dd, dd_mag, wgt, sum_mag, kst64, sig64, q10s;
  logic signed [31:0] commit_val, ema_new, ema_sig;
  logic [39:0] d10_q, d10_n;

  assign lb_k  = lb_r[k_r];
  assign per_k = per_r[k_r];
  assign opt_ok = (lb_r[0] != 8'd0) && (lb_r[0] < lb_r[1]) && (lb_r[1] < lb_r[2])
    && (lb_r[2] < lb_r[3]) && (32'(lb_r[3]) < 32'(HISTORY_DEPTH))
    && (per_r[0] != 16'd0) && (per_r[1] != 16'd0) && (per_r[2] != 16'd0)
    && (per_r[3] != 16'd0);

  assign pos_sum = {1'b0, wp_r} + DEPTH_W - (AW+1)'(lb_k);
  assign hist_rd_addr = (pos_sum >= DEPTH_W) ? AW'(pos_sum - DEPTH_W) : AW'(pos_sum);

  assign diff    = (x_r >= hist_rd) ? (x_r - hist_rd) : (hist_rd - x_r);
  assign div_qs  = neg_r ? -$signed({{(64-DW){1'b0}}, div_q})
                         : $signed({{(64-DW){1'b0}}, div_q});
  assign q10s    = neg_r ? -$signed({24'd0, d10_q}) : $signed({24'd0, d10_q});
  assign e64     = $signed({{32{e_r[31]}}, e_r});
  assign r64     = $signed({{32{r_r[31]}}, r_r});
  assign kst64   = $signed({{32{kst_r[31]}}, kst_r});
  assign sig64   = $signed({{32{st_rd[31]}}, st_rd});
  assign ema_new = sat32(e64 + div_qs);
  assign ema_sig = sat32(e64 + q10s);
  assign sum_mag = (sum_r < 0) ? -sum_r : sum_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    dd = (state_r == S_SIG) ? ((kst64 - sig64) <<< 1) : ((r64 - e64) <<< 1);
    dd_mag = (dd < 0) ? -dd : dd;
  end

  // divide by ten: estimate n*0.8 by shifts and adds, scale, then one-step fixup
  always_comb begin
    d10_q = dq_r;
    d10_n = dn_r;
    case (d10_step_r)
      3'd0:    d10_q = dq_r + (dq_r >> 4);
      3'd1:    d10_q = dq_r + (dq_r >> 8);
      3'd2:    d10_q = dq_r + (dq_r >> 16);
      3'd3:    d10_q = dq_r + (dq_r >> 32);
      3'd4:    d10_q = dq_r >> 3;
      3'd5:    d10_n = dn_r - ((dq_r << 3) + (dq_r << 1));
      default: d10_q = dq_r + ((dn_r >= 40'(KST_DIV)) ? 40'd1 : 40'd0);
    endcase
  end

  always_comb begin
    wgt = $signed({{32{commit_val[31]}}, commit_val});
    case (k_r)
      2'd0:    wgt = wgt;
      2'd1:    wgt = wgt <<< 1;
      2'd2:    wgt = wgt + (wgt <<< 1);
      default: wgt = wgt <<< 2;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r; x_nxt = x_r; last_nxt = last_r; wp_nxt = wp_r; idx_nxt = idx_r;
    fault_nxt = fault_r; neg_nxt = neg_r; e_nxt = e_r; r_nxt = r_r;
    kst_nxt = kst_r; sig_nxt = sig_r; sum_nxt = sum_r;
    dq_nxt = dq_r; dn_nxt = dn_r; d10_step_nxt = d10_step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    hist_rd_en = 1'b0; hist_wr_en = 1'b0;
    st_rd_en = 1'b0; st_rd_addr = {1'b0, k_r};
    st_wr_en = 1'b0; st_wr_addr = {1'b0, k_r}; st_wr_data = '0; st_clear = 1'b0;
    div_start = 1'b0; div_dvd = '0; div_dsr = '0;
    commit = 1'b0; commit_val = r_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_data.price_sample;
          last_nxt = in_data.last_in_series;
          k_nxt = 2'd0;
          sum_nxt = '0;
          state_nxt = opt_ok ? S_LOOK : S_INV;
        end
      end
      S_LOOK: begin
        if (idx_r >= {1'b0, lb_k}) begin
          hist_rd_en = 1'b1;
          st_rd_en = 1'b1;
          state_nxt = S_ROC;
        end else if (k_r == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_ROC: begin
        e_nxt = st_rd;
        if (hist_rd == 32'd0) begin
          fault_nxt = 1'b1;
          r_nxt = (x_r != 32'd0) ? S32_MAX : 32'sd0;
          state_nxt = S_EMA;
        end else begin
          div_start = 1'b1;
          div_dvd = {diff, {FRACTION_BITS{1'b0}}};
          div_dsr = hist_rd;
          neg_nxt = x_r < hist_rd;
          state_nxt = S_ROCW;
        end
      end
      S_ROCW: begin
        if (div_done) begin
          if (div_q > DW'(32'h7FFFFFFF)) begin
            r_nxt = neg_r ? S32_MIN : S32_MAX;
          end else begin
            r_nxt = div_qs[31:0];
          end
          state_nxt = S_EMA;
        end
      end
      S_EMA: begin
        if (idx_r == {1'b0, lb_k}) begin
          commit = 1'b1;
          commit_val = r_r;
        end else begin
          div_start = 1'b1;
          div_dvd = dd_mag[DW-1:0];
          div_dsr = {16'd0, per_k} + 32'd1;
          neg_nxt = dd < 0;
          state_nxt = S_EMAW;
        end
      end
      S_EMAW: begin
        if (div_done) begin
          commit = 1'b1;
          commit_val = ema_new;
        end
      end
      S_KST: begin
        dn_nxt = sum_mag[39:0];
        dq_nxt = (sum_mag[39:0] >> 1) + (sum_mag[39:0] >> 2);
        d10_step_nxt = 3'd0;
        neg_nxt = sum_r < 0;
        state_nxt = S_KSTW;
      end
      S_KSTW: begin
        if (d10_step_r == D10_LAST) begin
          kst_nxt = sat32(q10s);
          st_rd_en = 1'b1;
          st_rd_addr = ST_SIG;
          state_nxt = S_SIG;
        end else begin
          dq_nxt = d10_q;
          dn_nxt = d10_n;
          d10_step_nxt = d10_step_r + 3'd1;
        end
      end
      S_SIG: begin
        if (idx_r == {1'b0, lb_r[3]}) begin
          st_wr_en = 1'b1;
          st_wr_addr = ST_SIG;
          st_wr_data = kst_r;
          sig_nxt = kst_r;
          state_nxt = S_OUT;
        end else begin
          e_nxt = st_rd;
          dn_nxt = dd_mag[39:0];
          dq_nxt = (dd_mag[39:0] >> 1) + (dd_mag[39:0] >> 2);
          d10_step_nxt = 3'd0;
          neg_nxt = dd < 0;
          state_nxt = S_SIGW;
        end
      end
      S_SIGW: begin
        if (d10_step_r == D10_LAST) begin
          st_wr_en = 1'b1;
          st_wr_addr = ST_SIG;
          st_wr_data = ema_sig;
          sig_nxt = ema_sig;
          state_nxt = S_OUT;
        end else begin
          dq_nxt = d10_q;
          dn_nxt = d10_n;
          d10_step_nxt = d10_step_r + 3'd1;
        end
      end
      S_OUT: begin
        if (idx_r < {1'b0, lb_r[3]} || out_free) begin
          if (idx_r >= {1'b0, lb_r[3]}) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.kst_value = kst_r;
            out_data_nxt.signal_value = sig_r;
            out_data_nxt.options_invalid = 1'b0;
            out_data_nxt.divide_fault = fault_r;
          end
          hist_wr_en = 1'b1;
          wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
          if (idx_r != INDEX_MAX) begin
            idx_nxt = idx_r + 9'd1;
          end
          if (last_r) begin
            wp_nxt = '0; idx_nxt = '0; fault_nxt = 1'b0; st_clear = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_INV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.kst_value = '0;
          out_data_nxt.signal_value = '0;
          out_data_nxt.options_invalid = 1'b1;
          out_data_nxt.divide_fault = 1'b0;
          if (last_r) begin
            wp_nxt = '0; idx_nxt = '0; fault_nxt = 1'b0; st_clear = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (commit) begin
      st_wr_en = 1'b1;
      st_wr_data = commit_val;
      sum_nxt = sum_r + wgt;
      if (k_r == 2'd3) begin
        state_nxt = S_KST;
      end else begin
        k_nxt = k_r + 2'd1;
        state_nxt = S_LOOK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= '0;
      idx_r <= '0;
      fault_r <= 1'b0;
      out_valid_r <= 1'b0;
      lb_r[0] <= 8'd10; lb_r[1] <= 8'd15; lb_r[2] <= 8'd20; lb_r[3] <= 8'd30;
      per_r[0] <= 16'd10; per_r[1] <= 16'd10; per_r[2] <= 16'd10; per_r[3] <= 16'd15;
    end else begin
      state_r <= state_nxt;
      wp_r <= wp_nxt;
      idx_r <= idx_nxt;
      fault_r <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOOKBACK_1: lb_r[0] <= cfg_data[7:0];
          REG_LOOKBACK_2: lb_r[1] <= cfg_data[7:0];
          REG_LOOKBACK_3: lb_r[2] <= cfg_data[7:0];
          REG_LOOKBACK_4: lb_r[3] <= cfg_data[7:0];
          REG_PERIOD_1:   per_r[0] <= cfg_data;
          REG_PERIOD_2:   per_r[1] <= cfg_data;
          REG_PERIOD_3:   per_r[2] <= cfg_data;
          REG_PERIOD_4:   per_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
    k_r <= k_nxt; x_r <= x_nxt; last_r <= last_nxt; neg_r <= neg_nxt;
    e_r <= e_nxt; r_r <= r_nxt; kst_r <= kst_nxt; sig_r <= sig_nxt;
    sum_r <= sum_nxt; out_data_r <= out_data_nxt;
    dq_r <= dq_nxt; dn_r <= dn_nxt; d10_step_r <= d10_step_nxt;
  end

  kst_hist_ram #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
    .clk(clk), .wr_en(hist_wr_en), .wr_addr(wp_r), .wr_data(x_r),
    .rd_en(hist_rd_en), .rd_addr(hist_rd_addr), .rd_data(hist_rd)
  );

  kst_state_ram u_state (
    .clk(clk), .rst_n(rst_n), .clear(st_clear),
    .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_data),
    .rd_en(st_rd_en), .rd_addr(st_rd_addr), .rd_data(st_rd)
  );

  kst_div #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
endmodule
`default_nettype wire

/* tb/know_sure_thing_oscillator_top_tb.sv */
// Self-checking testbench for know_sure_thing_oscillator_top. It models every accepted sample,
// predicts the KST and signal values and flags of each result and checks each result transaction in order.
// Depends on kst_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module know_sure_thing_oscillator_top_tb;
  import kst_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kst_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kst_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_LOOKBACK_1;
  logic [15:0] cfg_data = '0;

  know_sure_thing_oscillator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  localparam int DRAIN_CYCLES = 700;
  localparam int FRACTION_SHIFT = 24;

  kst_in_t  sample_q[$];
  kst_out_t kst_expect_q[$];
  bit idling_on = 1'b1;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_faults = 0;
  int n_invalid = 0;
  int n_errors = 0;

  // predictor state
  logic [7:0]         lookback[4];
  logic [15:0]        period[4];
  logic [31:0]        price_ring[256];
  logic [8:0]         series_idx;
  logic [7:0]         wr_ptr;
  logic signed [31:0] smooth_rate[4];
  logic signed [31:0] sig_avg;
  bit                 fault_flag;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFFFFFF) return S32_MAX;
    if (v < -64'sh80000000) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic void restart_series();
    series_idx = '0;
    wr_ptr = '0;
    for (int k = 0; k < 4; k++) smooth_rate[k] = '0;
    sig_avg = '0;
    fault_flag = 1'b0;
  endfunction

  function automatic logic signed [31:0] rate_of(logic [31:0] x, logic [7:0] back);
    logic [7:0] pos;
    logic [31:0] old;
    logic [63:0] q;
    pos = wr_ptr - back;
    old = price_ring[pos];
    if (old == 0) begin
      fault_flag = 1'b1;
      return (x != 0) ? S32_MAX : 32'sd0;
    end
    if (x >= old) begin
      q = (64'(x - old) << FRACTION_SHIFT) / 64'(old);
      return (q > 64'h7FFFFFFF) ? S32_MAX : signed'(q[31:0]);
    end
    q = (64'(old - x) << FRACTION_SHIFT) / 64'(old);
    if (q > 64'h7FFFFFFF) return S32_MIN;
    return -signed'(q[31:0]);
  endfunction

  function automatic logic signed [31:0] ema_step(logic signed [31:0] e,
                                                  logic signed [31:0] r, longint p);
    longint d;
    d = 2 * (longint'(r) - longint'(e));
    return clamp32(longint'(e) + d / (p + 1));
  endfunction

  function automatic void predict_sample(kst_in_t it);
    bit ok;
    longint sum;
    logic signed [31:0] r;
    logic signed [31:0] kst;
    kst_out_t res;
    ok = lookback[0] >= 1 && lookback[0] < lookback[1] && lookback[1] < lookback[2]
      && lookback[2] < lookback[3] && period[0] != 0 && period[1] != 0
      && period[2] != 0 && period[3] != 0;
    if (!ok) begin
      res = '0;
      res.options_invalid = 1'b1;
      kst_expect_q.push_back(res);
      if (it.last_in_series) restart_series();
      return;
    end
    for (int k = 0; k < 4; k++) begin
      if (series_idx >= lookback[k]) begin
        r = rate_of(it.price_sample, lookback[k]);
        smooth_rate[k] = (series_idx == lookback[k]) ? r :
                         ema_step(smooth_rate[k], r, longint'(period[k]));
      end
    end
    if (series_idx >= lookback[3]) begin
      sum = longint'(smooth_rate[0]) + 2 * longint'(smooth_rate[1])
          + 3 * longint'(smooth_rate[2]) + 4 * longint'(smooth_rate[3]);
      kst = clamp32(sum / 10);
      sig_avg = (series_idx == lookback[3]) ? kst : ema_step(sig_avg, kst, 9);
      res.kst_value = kst;
      res.signal_value = sig_avg;
      res.options_invalid = 1'b0;
      res.divide_fault = fault_flag;
      kst_expect_q.push_back(res);
    end
    price_ring[wr_ptr] = it.price_sample;
    wr_ptr = wr_ptr + 8'd1;
    if (series_idx < INDEX_MAX) series_idx = series_idx + 9'd1;
    if (it.last_in_series) restart_series();
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sample(in_data);
        n_samples++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (idling_on && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    kst_out_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (kst_expect_q.size() == 0) begin
          $error("unexpected result transaction kst=%0d", out_data.kst_value);
          n_errors++;
        end else begin
          exp_res = kst_expect_q.pop_front();
          n_results++;
          if (out_data.divide_fault) n_faults++;
          if (out_data.options_invalid) n_invalid++;
          if (out_data.kst_value !== exp_res.kst_value) begin
            $error("kst_value expected %0d actual %0d", exp_res.kst_value, out_data.kst_value);
            n_errors++;
          end
          if (out_data.signal_value !== exp_res.signal_value) begin
            $error("signal_value expected %0d actual %0d",
                   exp_res.signal_value, out_data.signal_value);
            n_errors++;
          end
          if (out_data.options_invalid !== exp_res.options_invalid) begin
            $error("options_invalid expected %0b actual %0b",
                   exp_res.options_invalid, out_data.options_invalid);
            n_errors++;
          end
          if (out_data.divide_fault !== exp_res.divide_fault) begin
            $error("divide_fault expected %0b actual %0b",
                   exp_res.divide_fault, out_data.divide_fault);
            n_errors++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_cnt = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_PERIOD_1) lookback[idx] = val[7:0];
    else period[idx - REG_PERIOD_1] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_options(int l1, int l2, int l3, int l4, int p1, int p2, int p3, int p4);
    write_reg(REG_LOOKBACK_1, 16'(l1));
    write_reg(REG_LOOKBACK_2, 16'(l2));
    write_reg(REG_LOOKBACK_3, 16'(l3));
    write_reg(REG_LOOKBACK_4, 16'(l4));
    write_reg(REG_PERIOD_1, 16'(p1));
    write_reg(REG_PERIOD_2, 16'(p2));
    write_reg(REG_PERIOD_3, 16'(p3));
    write_reg(REG_PERIOD_4, 16'(p4));
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (sample_q.size() > 0 || in_valid || kst_expect_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(logic [31:0] x, logic last);
    kst_in_t it;
    it.price_sample = x;
    it.last_in_series = last;
    sample_q.push_back(it);
  endtask

  // queue whole series, mostly well formed price walks, some noise and cut-short series
  task automatic queue_series(int total);
    int added;
    int len;
    int mode;
    logic [31:0] p;
    logic [31:0] x;
    int step;
    added = 0;
    while (added < total) begin
      mode = $urandom_range(0, 9);
      len = (mode == 9) ? $urandom_range(1, lookback[3]) :
            int'(lookback[3]) + $urandom_range(1, 40);
      if (len > total - added) len = total - added;
      p = $urandom_range(32'h0000_1000, 32'h7FFF_0000);
      for (int i = 0; i < len; i++) begin
        step = $urandom_range(0, 1000) - 500;
        p = p + 32'(step * int'(p >> 12));
        if (p == 0) p = 32'h0001_0000;
        case (mode)
          0: x = $urandom();
          1: x = ($urandom_range(0, 5) == 0) ? 32'h0 : p;
          2: x = ($urandom_range(0, 7) == 0) ? $urandom() : p;
          default: x = p;
        endcase
        push_sample(x, i == len - 1);
      end
      added += len;
    end
  endtask

  initial begin
    int l1;
    int l2;
    int l3;
    lookback[0] = 8'd10; lookback[1] = 8'd15; lookback[2] = 8'd20; lookback[3] = 8'd30;
    period[0] = 16'd10; period[1] = 16'd10; period[2] = 16'd10; period[3] = 16'd15;
    for (int i = 0; i < 256; i++) price_ring[i] = '0;
    restart_series();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero old sample, zero over zero, full-scale swings, series restart
    set_options(1, 2, 3, 4, 1, 1, 1, 1);
    push_sample(32'h0, 1'b0);
    push_sample(32'h0, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0001, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0001, 1'b0);
    push_sample(32'h0, 1'b0);
    push_sample(32'h0, 1'b1);
    for (int i = 0; i < 8; i++) push_sample(32'h0001_0000 << (i % 4), 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h5555_AAAA, 1'b0);
    push_sample(32'hAAAA_5555, 1'b1);
    queue_series(180);
    wait_idle();

    set_options(10, 15, 20, 30, 10, 10, 10, 15);
    queue_series(350);
    wait_idle();

    set_options(252, 253, 254, 255, 65535, 65534, 2, 3);
    queue_series(300);
    wait_idle();

    set_options(5, 5, 9, 12, 1, 1, 1, 1);
    queue_series(25);
    wait_idle();
    set_options(2, 4, 6, 8, 0, 3, 3, 3);
    queue_series(25);
    wait_idle();
    set_options(0, 1, 2, 3, 3, 3, 3, 3);
    queue_series(20);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      l1 = $urandom_range(1, 20);
      l2 = l1 + $urandom_range(1, 15);
      l3 = l2 + $urandom_range(1, 15);
      set_options(l1, l2, l3, l3 + $urandom_range(1, 20), $urandom_range(1, 300),
                  $urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(1, 65535));
      if (ph == 3) idling_on = 1'b0;
      queue_series(140);
      wait_idle();
    end

    $display("covered %0d samples, %0d results (%0d with divide fault, %0d invalid options)",
             n_samples, n_results, n_faults, n_invalid);
    $display("configurations: defaults, minimal and maximal lookbacks, invalid options, random");
    if (n_errors == 0) begin
      $display("know_sure_thing_oscillator_top_tb: clean");
    end else begin
      $display("know_sure_thing_oscillator_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("know_sure_thing_oscillator_top_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
